>>> design/first_fit_line_allocator_defines.svh
// Assertion macros for the first-fit line allocator.
`ifndef FIRST_FIT_LINE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_LINE_ALLOCATOR_DEFINES_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define FFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FFLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/ffla_pkg.sv
// Types and codes shared by the first-fit line allocator.
`timescale 1ns / 1ps
package ffla_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        STATUS_OK     = 3'd0,
        STATUS_NOFIT  = 3'd1,
        STATUS_RANGE  = 3'd2,
        STATUS_TOOBIG = 3'd3,
        STATUS_FULL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_DROP,
        MODE_INS
    } t_mode;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    typedef struct packed {
        logic shift;
    } t_ring_ctrl;

endpackage

>>> design/ffla_cell.sv
// One extent slot of the ring: holds start and length, takes its neighbour's on a shift.
`timescale 1ns / 1ps
module ffla_cell #(
    parameter int WIDTH = 42
) (
    input  logic                  i_clk,
    input  ffla_pkg::t_ring_ctrl  i_ctrl,
    input  logic [WIDTH-1:0]      i_d,
    output logic [WIDTH-1:0]      o_q
);
    import ffla_pkg::*;

    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> design/first_fit_line_allocator.sv
// Top level of the first-fit line allocator: request control and the extent ring.
`timescale 1ns / 1ps
`include "first_fit_line_allocator_defines.svh"
// Free extents sit in a ring of MAX_EXTENTS cells kept in start order, read at its head
// (a drop also reads the next cell). Allocate and free requests take one full rotation
// to search, a decision state, and when the table changes a second rotation that
// rewrites it while dropping, merging or inserting on the fly; the request is taken in
// the idle state and the result loaded in the final state. Reinitialise skips the
// search; a request that leaves the table unchanged (no fit, zero count, a failed free
// check, table full) skips the rewrite; operation three goes from the decision straight
// to the final state. One request is in work at a time; a new one is taken while the
// last result still waits in the output register. No clearing pass follows reset.
module first_fit_line_allocator #(
    parameter int LINE_COUNT  = 1048576,
    parameter int MAX_EXTENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [19:0] i_start_line,
    input  logic [20:0] i_line_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [19:0] o_alloc_start,
    output logic [20:0] o_free_total
);
    import ffla_pkg::*;

    localparam int LENW = $clog2(LINE_COUNT + 1);
    localparam int W    = (LENW > 21) ? LENW : 21;
    localparam int CW   = W + 2;
    localparam int IW   = $clog2(MAX_EXTENTS);
    localparam int UW   = IW + 1;
    localparam logic [CW-1:0] LC   = CW'(LINE_COUNT);
    localparam logic [UW-1:0] MAXU = UW'(MAX_EXTENTS);
    localparam logic [UW-1:0] LAST = UW'(MAX_EXTENTS - 1);

    // ring
    t_ring_ctrl       w_ctrl;
    logic [2*W-1:0]   w_q [MAX_EXTENTS];
    logic [2*W-1:0]   w_tail;

    genvar k;
    generate
        for (k = 0; k < MAX_EXTENTS; k++) begin : g_cell
            logic [2*W-1:0] w_d;
            if (k == MAX_EXTENTS - 1) begin : g_last
                assign w_d = w_tail;
            end else begin : g_mid
                assign w_d = w_q[k+1];
            end
            ffla_cell #(.WIDTH(2*W)) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_d    (w_d),
                .o_q    (w_q[k])
            );
        end
    endgenerate

    // control registers
    t_state       r_state, n_state;
    logic [UW-1:0] r_t, n_t;
    logic [UW-1:0] r_used, n_used;
    logic [W-1:0]  r_total, n_total;
    logic [19:0]   r_base, n_base;
    logic          r_out_valid, n_out_valid;

    // request and working payload
    logic [1:0]   r_op, n_op;
    logic [19:0]  r_start, n_start;
    logic [20:0]  r_count, n_count;
    logic         r_found, n_found;
    logic [UW-1:0] r_fidx, n_fidx;
    logic [W-1:0] r_fs, n_fs, r_fl, n_fl;
    logic         r_hasl, n_hasl;
    logic [UW-1:0] r_lidx, n_lidx;
    logic [W-1:0] r_ls, n_ls, r_ll, n_ll;
    logic         r_hasr, n_hasr;
    logic [UW-1:0] r_ridx, n_ridx;
    logic [W-1:0] r_rl, n_rl;
    logic         r_posf, n_posf;
    logic [UW-1:0] r_pidx, n_pidx;
    t_mode        r_mode, n_mode;
    logic [UW-1:0] r_didx, n_didx;
    logic [W-1:0] r_new_s, n_new_s, r_new_l, n_new_l;
    logic         r_mod_en, n_mod_en;
    logic [UW-1:0] r_midx, n_midx;
    logic [W-1:0] r_mod_s, n_mod_s, r_mod_l, n_mod_l;
    logic [2*W-1:0] r_prev;
    t_status      r_res_status, n_res_status;
    logic [W-1:0] r_res_grant, n_res_grant;
    logic [2:0]   r_o_status, n_o_status;
    logic [19:0]  r_o_grant, n_o_grant;
    logic [20:0]  r_o_total, n_o_total;

    // head of ring, widened for compares
    logic [CW-1:0] w_hs, w_hl, w_he, w_rs, w_rc, w_rend, w_base, w_room;
    logic          w_hvalid;

    assign w_hs     = CW'(w_q[0][2*W-1:W]);
    assign w_hl     = CW'(w_q[0][W-1:0]);
    assign w_he     = w_hs + w_hl;
    assign w_rs     = CW'(r_start);
    assign w_rc     = CW'(r_count);
    assign w_rend   = w_rs + w_rc;
    assign w_base   = CW'(r_base);
    assign w_room   = (w_base < LC) ? (LC - w_base) : '0;
    assign w_hvalid = r_t < r_used;

    assign w_ctrl.shift = (r_state == ST_SCAN) || (r_state == ST_WRITE);

    // rewrite stream: drop looks one cell ahead, insert replays the previous head
    always_comb begin
        logic [2*W-1:0] v_src;
        logic [UW-1:0]  v_oidx;
        logic           v_ins;
        v_src  = w_q[0];
        v_oidx = r_t;
        v_ins  = 1'b0;
        if (r_state == ST_WRITE) begin
            unique case (r_mode)
                MODE_DROP: begin
                    if (r_t >= r_didx) begin
                        v_src  = w_q[1];
                        v_oidx = r_t + UW'(1);
                    end
                end
                MODE_INS: begin
                    if (r_t == r_pidx) begin
                        v_src = {r_new_s, r_new_l};
                        v_ins = 1'b1;
                    end else if (r_t > r_pidx) begin
                        v_src  = r_prev;
                        v_oidx = r_t - UW'(1);
                    end
                end
                default: ;
            endcase
            if (r_mod_en && !v_ins && v_oidx == r_midx) begin
                v_src = {r_mod_s, r_mod_l};
            end
        end
        w_tail = v_src;
    end

    always_comb begin
        n_state      = r_state;
        n_t          = r_t;
        n_used       = r_used;
        n_total      = r_total;
        n_base       = i_cfg_we ? i_cfg_data : r_base;
        n_out_valid  = r_out_valid && i_stall;
        n_op         = r_op;
        n_start      = r_start;
        n_count      = r_count;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_fs         = r_fs;
        n_fl         = r_fl;
        n_hasl       = r_hasl;
        n_lidx       = r_lidx;
        n_ls         = r_ls;
        n_ll         = r_ll;
        n_hasr       = r_hasr;
        n_ridx       = r_ridx;
        n_rl         = r_rl;
        n_posf       = r_posf;
        n_pidx       = r_pidx;
        n_mode       = r_mode;
        n_didx       = r_didx;
        n_new_s      = r_new_s;
        n_new_l      = r_new_l;
        n_mod_en     = r_mod_en;
        n_midx       = r_midx;
        n_mod_s      = r_mod_s;
        n_mod_l      = r_mod_l;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_o_status   = r_o_status;
        n_o_grant    = r_o_grant;
        n_o_total    = r_o_total;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op     = i_operation;
                    n_start  = i_start_line;
                    n_count  = i_line_count;
                    n_t      = '0;
                    n_found  = 1'b0;
                    n_hasl   = 1'b0;
                    n_hasr   = 1'b0;
                    n_posf   = 1'b0;
                    n_pidx   = r_used;
                    n_mode   = MODE_NONE;
                    n_mod_en = 1'b0;
                    n_res_grant = '0;
                    if (i_operation == OP_ALLOC || i_operation == OP_FREE) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_SCAN: begin
                if (w_hvalid) begin
                    if (!r_found && w_rc <= w_hl) begin
                        n_found = 1'b1;
                        n_fidx  = r_t;
                        n_fs    = w_q[0][2*W-1:W];
                        n_fl    = w_q[0][W-1:0];
                    end
                    if (!r_hasl && w_he == w_rs) begin
                        n_hasl = 1'b1;
                        n_lidx = r_t;
                        n_ls   = w_q[0][2*W-1:W];
                        n_ll   = w_q[0][W-1:0];
                    end
                    if (!r_hasr && w_hs == w_rend) begin
                        n_hasr = 1'b1;
                        n_ridx = r_t;
                        n_rl   = w_q[0][W-1:0];
                    end
                    if (!r_posf && w_hs >= w_rs) begin
                        n_posf = 1'b1;
                        n_pidx = r_t;
                    end
                end
                if (r_t == LAST) begin
                    n_t     = '0;
                    n_state = ST_DECIDE;
                end else begin
                    n_t = r_t + UW'(1);
                end
            end
            ST_DECIDE: begin
                n_res_status = STATUS_OK;
                n_state      = ST_FIN;
                unique case (r_op)
                    OP_ALLOC: begin
                        if (!r_found) begin
                            n_res_status = STATUS_NOFIT;
                        end else begin
                            n_res_grant = r_fs;
                            if (r_count != '0) begin
                                n_mod_en = 1'b1;
                                n_midx   = r_fidx;
                                n_mod_s  = W'(CW'(r_fs) + w_rc);
                                n_mod_l  = W'(CW'(r_fl) - w_rc);
                                if (CW'(r_fl) == w_rc) begin
                                    n_mode = MODE_DROP;
                                    n_didx = r_fidx;
                                    n_used = r_used - UW'(1);
                                end
                                n_total = (CW'(r_total) >= w_rc) ?
                                          W'(CW'(r_total) - w_rc) : '0;
                                n_state = ST_WRITE;
                            end
                        end
                    end
                    OP_FREE: begin
                        if (r_count == '0) begin
                            n_res_status = STATUS_OK;
                        end else if (w_rs < w_base || w_rs >= LC) begin
                            n_res_status = STATUS_RANGE;
                        end else if (w_rend > LC || w_rc + CW'(r_total) > w_room) begin
                            n_res_status = STATUS_TOOBIG;
                        end else if (!r_hasl && !r_hasr && r_used >= MAXU) begin
                            n_res_status = STATUS_FULL;
                        end else begin
                            n_total = W'(CW'(r_total) + w_rc);
                            n_state = ST_WRITE;
                            if (r_hasl && r_hasr && r_lidx != r_ridx) begin
                                // both neighbours touch: fold right into left
                                n_mod_en = 1'b1;
                                n_midx   = r_lidx;
                                n_mod_s  = r_ls;
                                n_mod_l  = W'(CW'(r_ll) + w_rc + CW'(r_rl));
                                n_mode   = MODE_DROP;
                                n_didx   = r_ridx;
                                n_used   = r_used - UW'(1);
                            end else if (r_hasl) begin
                                n_mod_en = 1'b1;
                                n_midx   = r_lidx;
                                n_mod_s  = r_ls;
                                n_mod_l  = W'(CW'(r_ll) + w_rc);
                            end else if (r_hasr) begin
                                n_mod_en = 1'b1;
                                n_midx   = r_ridx;
                                n_mod_s  = W'(r_start);
                                n_mod_l  = W'(CW'(r_rl) + w_rc);
                            end else begin
                                n_mode  = MODE_INS;
                                n_new_s = W'(r_start);
                                n_new_l = W'(r_count);
                                n_used  = r_used + UW'(1);
                            end
                        end
                    end
                    OP_REINIT: begin
                        n_used  = '0;
                        n_total = '0;
                        if (w_base >= LC) begin
                            n_res_status = STATUS_RANGE;
                        end else begin
                            n_mode  = MODE_INS;
                            n_pidx  = '0;
                            n_new_s = W'(r_base);
                            n_new_l = W'(LC - w_base);
                            n_used  = UW'(1);
                            n_total = W'(LC - w_base);
                            n_state = ST_WRITE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_WRITE: begin
                if (r_t == LAST) begin
                    n_t     = '0;
                    n_state = ST_FIN;
                end else begin
                    n_t = r_t + UW'(1);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_grant   = r_res_grant[19:0];
                    n_o_total   = r_total[20:0];
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_t         <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_t         <= n_t;
            r_used      <= n_used;
            r_total     <= n_total;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_start      <= n_start;
        r_count      <= n_count;
        r_found      <= n_found;
        r_fidx       <= n_fidx;
        r_fs         <= n_fs;
        r_fl         <= n_fl;
        r_hasl       <= n_hasl;
        r_lidx       <= n_lidx;
        r_ls         <= n_ls;
        r_ll         <= n_ll;
        r_hasr       <= n_hasr;
        r_ridx       <= n_ridx;
        r_rl         <= n_rl;
        r_posf       <= n_posf;
        r_pidx       <= n_pidx;
        r_mode       <= n_mode;
        r_didx       <= n_didx;
        r_new_s      <= n_new_s;
        r_new_l      <= n_new_l;
        r_mod_en     <= n_mod_en;
        r_midx       <= n_midx;
        r_mod_s      <= n_mod_s;
        r_mod_l      <= n_mod_l;
        r_prev       <= w_q[0];
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_o_status   <= n_o_status;
        r_o_grant    <= n_o_grant;
        r_o_total    <= n_o_total;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_alloc_start = r_o_grant;
    assign o_free_total  = r_o_total;

    `FFLA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= MAXU, "extent count above table size")
    `FFLA_ASSERT(a_total_bound, i_clk, i_rst_n, CW'(r_total) <= LC, "free total above line count")
    `FFLA_ASSERT(a_busy_after_take, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall, "request taken but block not busy")
    `FFLA_ASSERT(a_out_hold, i_clk, i_rst_n, (r_state == ST_FIN && r_out_valid && i_stall) |=> (r_state == ST_FIN), "result loaded over a stalled transfer")

endmodule
